// ----- hdl/bprr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_pkg
// Shared widths, codes, types and the remainder step for the base-P record
// reconstruction block.
// ----------------------------------------------------------------------------
package bprr_pkg;

    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int IDX_W      = 32;
    localparam int PMOD_W     = 33;
    localparam int LOGQ_W     = 7;
    localparam int ROWB_W     = 6;
    localparam int PACK_W     = 6;
    localparam int SHIFT_W    = ROWB_W + PACK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PMOD_W;

    // Two remainder bits per cycle over a 64-bit dividend
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DATA_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAIN_MODULUS = 2'd0,
        CFG_LOG_Q         = 2'd1,
        CFG_ROW_BITS      = 2'd2,
        CFG_PACKING       = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SLOT,
        S_SHIFT,
        S_EMIT
    } t_state;

    // Issue slot of the shared 32x32 multiplier
    typedef enum logic [2:0] {
        PH_WT_LL,
        PH_WT_LH,
        PH_WT_HL,
        PH_WP_LL,
        PH_WP_LH,
        PH_WP_HL,
        PH_DRAIN
    } t_mul_phase;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [PMOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PMOD_W-1:0] rem;
    } t_div_rsp;

    // One restoring step; rem < divisor <= 2^32, so rem[32] is always clear
    function automatic logic [PMOD_W-1:0] rem_step(
        input logic [PMOD_W-1:0] rem,
        input logic              bit_in,
        input logic [PMOD_W-1:0] divisor
    );
        logic [PMOD_W-1:0] tmp;
        tmp = {rem[PMOD_W-2:0], bit_in};
        return (tmp >= divisor) ? (tmp - divisor) : tmp;
    endfunction

endpackage

// ----- hdl/bprr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_in_if
// Digit input channel: valid/ready with one record digit per transfer.
// ----------------------------------------------------------------------------
interface bprr_in_if;
    logic                        valid;
    logic                        ready;
    logic [bprr_pkg::DATA_W-1:0] digit;
    logic [bprr_pkg::IDX_W-1:0]  entry_index;
    logic                        last;

    modport source (output valid, output digit, output entry_index, output last,
                    input ready);
    modport sink   (input valid, input digit, input entry_index, input last,
                    output ready);
endinterface

// ----- hdl/bprr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_out_if
// Result channel: valid/ready with one reconstructed element per transfer.
// ----------------------------------------------------------------------------
interface bprr_out_if;
    logic                        valid;
    logic                        ready;
    logic [bprr_pkg::DATA_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

// ----- hdl/base_p_record_reconstruct.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_p_record_reconstruct
// Rebuilds one database entry from its base-P digits and optionally unpacks it.
// ----------------------------------------------------------------------------
// Digits arrive lowest first, one per transfer; the block is not ready while
// a digit is being worked on. Each digit is recentred (add P/2, keep log_q
// bits, reduce mod P), multiplied by the running weight P^k and added into a
// 64-bit accumulator; the weight then becomes P^(k+1). All arithmetic wraps
// mod 2^64. On the digit flagged last, the sum is optionally unpacked (field
// entry_index mod packing, row_bits wide) and sent out, and the state clears.
// Per digit: the accept in idle, a pass through the radix-4 remainder unit
// (skipped when P is 0), then the issue and drain phases of the shared 32x32
// multiplier. A last digit adds a second pass of the same remainder unit and
// a shift step when packing is enabled, then loads the output register,
// waiting while it is still held by the sink. The output register frees the
// block to take the next digit while a result waits. Configuration is to be
// written only while idle (the block does not enforce it) and is not read back.
// ----------------------------------------------------------------------------
module base_p_record_reconstruct (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bprr_in_if.sink                         i_in,
    bprr_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [bprr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bprr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DW = bprr_pkg::DATA_W;
    localparam int HW = bprr_pkg::HALF_W;

    // configuration
    logic [bprr_pkg::PMOD_W-1:0] r_pmod;
    logic [bprr_pkg::LOGQ_W-1:0] r_logq;
    logic [bprr_pkg::ROWB_W-1:0] r_rowb;
    logic [bprr_pkg::PACK_W-1:0] r_pack;

    // sequencer and datapath
    bprr_pkg::t_state     r_state, n_state;
    bprr_pkg::t_mul_phase r_phase, n_phase;
    logic [DW-1:0]                  r_t, n_t;          // recentred digit
    logic [bprr_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_last, n_last;
    logic [DW-1:0]                  r_acc, n_acc;
    logic [DW-1:0]                  r_weight, n_weight;
    logic [DW-1:0]                  r_wnext, n_wnext;  // weight * P in progress
    logic [DW-1:0]                  r_prod, n_prod;    // multiplier output reg
    logic [DW-1:0]                  r_res, n_res;      // value to emit
    logic [bprr_pkg::SHIFT_W-1:0]   r_shift, n_shift;
    logic                           r_out_valid, n_out_valid;
    logic [DW-1:0]                  r_elem, n_elem;

    bprr_pkg::t_div_req div_req;
    bprr_pkg::t_div_rsp div_rsp;

    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [DW-1:0] mul_p;
    logic [DW-1:0] prod_hi;     // low half of a cross product, moved up
    logic [DW-1:0] rc_sum;
    logic [DW-1:0] rc_val;

    bprr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmod <= bprr_pkg::PMOD_W'(2);
            r_logq <= bprr_pkg::LOGQ_W'(32);
            r_rowb <= bprr_pkg::ROWB_W'(1);
            r_pack <= '0;
        end else if (i_cfg_we) begin
            unique case (bprr_pkg::t_cfg_idx'(i_cfg_idx))
                bprr_pkg::CFG_PLAIN_MODULUS: r_pmod <= i_cfg_data;
                bprr_pkg::CFG_LOG_Q:         r_logq <= i_cfg_data[bprr_pkg::LOGQ_W-1:0];
                bprr_pkg::CFG_ROW_BITS:      r_rowb <= i_cfg_data[bprr_pkg::ROWB_W-1:0];
                bprr_pkg::CFG_PACKING:       r_pack <= i_cfg_data[bprr_pkg::PACK_W-1:0];
                default: ;
            endcase
        end
    end

    // recentre on the way in: add P/2, keep log_q bits (all when log_q >= 64)
    assign rc_sum = i_in.digit + DW'(r_pmod[bprr_pkg::PMOD_W-1:1]);
    assign rc_val = r_logq[bprr_pkg::LOGQ_W-1] ? rc_sum
                  : (rc_sum & ~({DW{1'b1}} << r_logq[bprr_pkg::LOGQ_W-2:0]));

    // shared multiplier, registered before the add
    assign mul_p   = DW'(mul_a) * DW'(mul_b);
    assign prod_hi = {r_prod[HW-1:0], {HW{1'b0}}};

    assign o_out.valid   = r_out_valid;
    assign o_out.element = r_elem;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_t         = r_t;
        n_idx       = r_idx;
        n_last      = r_last;
        n_acc       = r_acc;
        n_weight    = r_weight;
        n_wnext     = r_wnext;
        n_prod      = r_prod;
        n_res       = r_res;
        n_shift     = r_shift;
        n_out_valid = r_out_valid;
        n_elem      = r_elem;
        div_req     = '0;
        mul_a       = '0;
        mul_b       = '0;
        i_in.ready  = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bprr_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_idx  = i_in.entry_index;
                    n_last = i_in.last;
                    n_t    = rc_val;
                    if (r_pmod != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = rc_val;
                        div_req.divisor  = r_pmod;
                        n_state          = bprr_pkg::S_REDUCE;
                    end else begin
                        // P of zero: no reduction
                        n_phase = bprr_pkg::PH_WT_LL;
                        n_state = bprr_pkg::S_MUL;
                    end
                end
            end

            bprr_pkg::S_REDUCE: begin
                if (div_rsp.done) begin
                    n_t     = DW'(div_rsp.rem);
                    n_phase = bprr_pkg::PH_WT_LL;
                    n_state = bprr_pkg::S_MUL;
                end
            end

            bprr_pkg::S_MUL: begin
                // issue: acc += w*t (three partials), then w*P (three partials)
                unique case (r_phase)
                    bprr_pkg::PH_WT_LL: begin mul_a = r_weight[HW-1:0]; mul_b = r_t[HW-1:0]; end
                    bprr_pkg::PH_WT_LH: begin mul_a = r_weight[HW-1:0]; mul_b = r_t[DW-1:HW]; end
                    bprr_pkg::PH_WT_HL: begin mul_a = r_weight[DW-1:HW]; mul_b = r_t[HW-1:0]; end
                    bprr_pkg::PH_WP_LL: begin mul_a = r_weight[HW-1:0]; mul_b = r_pmod[HW-1:0]; end
                    bprr_pkg::PH_WP_LH: begin
                        mul_a = r_weight[HW-1:0];
                        mul_b = HW'(r_pmod[bprr_pkg::PMOD_W-1:HW]);
                    end
                    bprr_pkg::PH_WP_HL: begin mul_a = r_weight[DW-1:HW]; mul_b = r_pmod[HW-1:0]; end
                    bprr_pkg::PH_DRAIN: ;
                    default: ;
                endcase
                n_prod = mul_p;

                // accumulate the partial registered from the previous phase
                unique case (r_phase)
                    bprr_pkg::PH_WT_LL: ;
                    bprr_pkg::PH_WT_LH: n_acc   = r_acc + r_prod;
                    bprr_pkg::PH_WT_HL: n_acc   = r_acc + prod_hi;
                    bprr_pkg::PH_WP_LL: n_acc   = r_acc + prod_hi;
                    bprr_pkg::PH_WP_LH: n_wnext = r_prod;
                    bprr_pkg::PH_WP_HL: n_wnext = r_wnext + prod_hi;
                    bprr_pkg::PH_DRAIN: n_weight = r_wnext + prod_hi;
                    default: ;
                endcase

                if (r_phase != bprr_pkg::PH_DRAIN) begin
                    n_phase = bprr_pkg::t_mul_phase'(r_phase + 3'd1);
                end else if (r_last) begin
                    n_res    = r_acc;
                    n_acc    = '0;
                    n_weight = DW'(1);
                    if (r_pack != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DW'(r_idx);
                        div_req.divisor  = bprr_pkg::PMOD_W'(r_pack);
                        n_state          = bprr_pkg::S_SLOT;
                    end else begin
                        n_state = bprr_pkg::S_EMIT;
                    end
                end else begin
                    n_state = bprr_pkg::S_IDLE;
                end
            end

            bprr_pkg::S_SLOT: begin
                // slot < packing <= 63, so six remainder bits suffice
                if (div_rsp.done) begin
                    n_shift = bprr_pkg::SHIFT_W'(div_rsp.rem[bprr_pkg::PACK_W-1:0])
                            * bprr_pkg::SHIFT_W'(r_rowb);
                    n_state = bprr_pkg::S_SHIFT;
                end
            end

            bprr_pkg::S_SHIFT: begin
                if (r_shift >= bprr_pkg::SHIFT_W'(DW)) begin
                    n_res = '0;
                end else begin
                    n_res = (r_res >> r_shift[bprr_pkg::ROWB_W-1:0])
                          & ~({DW{1'b1}} << r_rowb);
                end
                n_state = bprr_pkg::S_EMIT;
            end

            bprr_pkg::S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_elem      = r_res;
                    n_out_valid = 1'b1;
                    n_state     = bprr_pkg::S_IDLE;
                end
            end

            default: n_state = bprr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bprr_pkg::S_IDLE;
            r_phase     <= bprr_pkg::PH_WT_LL;
            r_acc       <= '0;
            r_weight    <= DW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_weight    <= n_weight;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_wnext <= n_wnext;
        r_prod  <= n_prod;
        r_res   <= n_res;
        r_shift <= n_shift;
        r_elem  <= n_elem;
    end

    // remainder results only land in the states that wait for them
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == bprr_pkg::S_REDUCE || r_state == bprr_pkg::S_SLOT))
        else $error("remainder done outside a waiting state");

    // reduced digit is below P
    a_reduced_below_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bprr_pkg::S_REDUCE && div_rsp.done) |=>
            (r_t < DW'(r_pmod)))
        else $error("recentred digit not reduced");

    // after the last digit the record state is back at its start
    a_cleared_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bprr_pkg::S_EMIT || r_state == bprr_pkg::S_SHIFT)
            |-> (r_acc == '0 && r_weight == DW'(1)))
        else $error("record state not cleared after last digit");

    // a digit that is not last ends without touching the output
    a_not_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bprr_pkg::S_MUL && r_phase == bprr_pkg::PH_DRAIN && !r_last)
            |=> (r_state == bprr_pkg::S_IDLE))
        else $error("non-last digit did not return to idle");

endmodule

// ----- hdl/bprr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprr_divider
// Iterative radix-4 remainder unit: 64-bit dividend, 33-bit divisor.
// ----------------------------------------------------------------------------
module bprr_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bprr_pkg::t_div_req i_req,
    output bprr_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [bprr_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [bprr_pkg::DATA_W-1:0]         r_num;
    logic [bprr_pkg::PMOD_W-1:0]         r_div;
    logic [bprr_pkg::PMOD_W-1:0]         r_rem;
    logic [bprr_pkg::PMOD_W-1:0]         rem_a;
    logic [bprr_pkg::PMOD_W-1:0]         rem_b;

    // two dependent steps per cycle, top dividend bits first
    assign rem_a = bprr_pkg::rem_step(r_rem, r_num[bprr_pkg::DATA_W-1], r_div);
    assign rem_b = bprr_pkg::rem_step(rem_a, r_num[bprr_pkg::DATA_W-2], r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + bprr_pkg::DIV_CNT_W'(1);
                if (r_cnt == bprr_pkg::DIV_CNT_W'(bprr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[bprr_pkg::DATA_W-3:0], 2'b00};
            r_rem <= rem_b;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running division");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_div != '0)) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("division restarted while busy");

endmodule

// ----- dv/tb_base_p_record_reconstruct.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base_p_record_reconstruct
// Self-checking bench for the base-P record reconstruction block.
// ----------------------------------------------------------------------------
// Digits are sent through the valid/ready input channel, and an in-bench
// predictor rebuilds each record the same way the block should: recentre,
// weight by P^k, accumulate, then unpack on the last digit. Every accepted
// element is compared with the oldest prediction. A short directed part hits
// the register extremes and corner cases. A long random part follows, with
// random register settings, random record lengths and random gaps on both
// sides. Register writes only happen once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_base_p_record_reconstruct;

    localparam int  CLK_HALF     = 5;
    localparam int  RST_CYCLES   = 4;
    localparam int  DIGIT_TARGET = 1250;
    // Covers the worst record digit plus the largest gaps on both sides, with margin
    localparam int  CYCLE_LIMIT  = 800_000;
    // Settle time after the last result before touching the registers
    localparam int  SETTLE       = 60;
    localparam int  MAX_REPORTS  = 10;
    localparam bit [63:0] ONES   = '1;
    localparam bit [32:0] P_MAX  = 33'h1_0000_0000;

    // ------------------------------------------------------------------
    // Expected-element store with its own copy of the datapath
    // ------------------------------------------------------------------
    class element_scoreboard;
        bit [32:0] p_mod;
        bit [6:0]  log_q;
        bit [5:0]  row_bits;
        bit [5:0]  packing;
        bit [63:0] acc;
        bit [63:0] wt;
        bit [63:0] expected_elements[$];
        int        n_digits;
        int        n_records;
        int        n_checked;
        int        n_errors;

        function new();
            p_mod    = 33'd2;
            log_q    = 7'd32;
            row_bits = 6'd1;
            packing  = 6'd0;
            acc      = '0;
            wt       = 64'd1;
        endfunction

        function void write_reg(bprr_pkg::t_cfg_idx idx, bit [32:0] data);
            case (idx)
                bprr_pkg::CFG_PLAIN_MODULUS: p_mod    = data;
                bprr_pkg::CFG_LOG_Q:         log_q    = data[6:0];
                bprr_pkg::CFG_ROW_BITS:      row_bits = data[5:0];
                bprr_pkg::CFG_PACKING:       packing  = data[5:0];
                default: ;
            endcase
        endfunction

        // add P/2 (wrapping), keep log_q bits, reduce mod P (P = 0 passes)
        function bit [63:0] recentre_digit(bit [63:0] d);
            bit [63:0] p64;
            bit [63:0] t;
            p64 = 64'(p_mod);
            t   = d + (p64 >> 1);
            if (log_q < 7'd64)
                t &= (64'd1 << log_q) - 64'd1;
            if (p64 != 64'd0)
                t = t % p64;
            return t;
        endfunction

        function bit [63:0] unpack_element(bit [63:0] v, bit [31:0] idx);
            bit [63:0] slot;
            bit [63:0] shift;
            bit [63:0] mask;
            if (packing == 6'd0)
                return v;
            slot  = 64'(idx) % 64'(packing);
            shift = slot * 64'(row_bits);
            if (shift >= 64'd64)
                return 64'd0;
            mask = (64'd1 << row_bits) - 64'd1;
            return (v >> shift) & mask;
        endfunction

        function void note_digit(bit [63:0] d, bit [31:0] idx, bit last);
            acc = acc + wt * recentre_digit(d);
            wt  = wt * 64'(p_mod);
            n_digits++;
            if (last) begin
                expected_elements = {expected_elements, unpack_element(acc, idx)};
                acc = '0;
                wt  = 64'd1;
                n_records++;
            end
        endfunction

        function void check_element(bit [63:0] got);
            bit [63:0] want;
            if (expected_elements.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("[%0t] unexpected element %h", $realtime, got);
                return;
            end
            want = expected_elements.pop_front();
            n_checked++;
            if (got !== want) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("[%0t] element mismatch: expected %h, got %h",
                             $realtime, want, got);
            end
        endfunction

        function int pending();
            return expected_elements.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bprr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bprr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bprr_in_if  dig_if();
    bprr_out_if elem_if();

    base_p_record_reconstruct DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (dig_if),
        .o_out      (elem_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    element_scoreboard sb = new();

    bit src_idle_on;     // sender draws gaps when set, else back-to-back
    bit sink_idle_on;    // receiver draws stalls when set
    int n_settings;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL base_p_record_reconstruct");
            $finish;
        end
    end

    // Monitors sample pre-edge values, so they see each transfer exactly once
    always @(posedge i_clk) begin
        if (i_rst_n && dig_if.valid && dig_if.ready)
            sb.note_digit(dig_if.digit, dig_if.entry_index, dig_if.last);
        if (i_rst_n && elem_if.valid && elem_if.ready)
            sb.check_element(elem_if.element);
    end

    // Result side: random stall before each transfer, then hold ready until
    // the element is taken
    initial begin
        int n;
        elem_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (n > 0) begin
                elem_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            elem_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!elem_if.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks; all start and end on a rising edge
    // ------------------------------------------------------------------
    task automatic send_digit(input bit [63:0] d, input bit [31:0] idx,
                              input bit last);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            dig_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        dig_if.valid       <= 1'b1;
        dig_if.digit       <= d;
        dig_if.entry_index <= idx;
        dig_if.last        <= last;
        @(posedge i_clk);
        while (!dig_if.ready) @(posedge i_clk);
    endtask

    task automatic cfg_write(input bprr_pkg::t_cfg_idx idx, input bit [32:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Only called with the block idle (after reset or after drain_phase)
    task automatic set_config(input bit [32:0] p, input bit [6:0] lq,
                              input bit [5:0] rb, input bit [5:0] pk);
        cfg_write(bprr_pkg::CFG_PLAIN_MODULUS, p);
        cfg_write(bprr_pkg::CFG_LOG_Q, 33'(lq));
        cfg_write(bprr_pkg::CFG_ROW_BITS, 33'(rb));
        cfg_write(bprr_pkg::CFG_PACKING, 33'(pk));
        i_cfg_we <= 1'b0;
        n_settings++;
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // Sender holds off until every element is back. Phases always close
    // on a last digit, so the block is idle after the settle time.
    task automatic drain_phase();
        dig_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Digit mix: full random, small, all ones or zero, wrapping near 2^64 with P/2,
    // and sitting just under the 2^log_q boundary
    function automatic bit [63:0] rand_digit();
        bit [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return 64'($urandom_range(0, 1000));
            1:       return ONES - 64'($urandom);
            2: begin
                if (sb.log_q < 7'd64)
                    return (64'd1 << sb.log_q) - 64'(sb.p_mod >> 1)
                           - 64'($urandom_range(0, 3));
                return r;
            end
            3:       return $urandom_range(0, 1) ? ONES : 64'd0;
            default: return r;
        endcase
    endfunction

    function automatic bit [31:0] rand_index();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 70);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(output bit [32:0] p, output bit [6:0] lq,
                                 output bit [5:0] rb, output bit [5:0] pk);
        case ($urandom_range(0, 9))
            0:       p = 33'd0;
            1:       p = 33'd1;
            2:       p = 33'd2 + 33'($urandom_range(0, 1));
            3:       p = P_MAX;
            4:       p = P_MAX - 33'd1;
            5:       p = 33'd1 << $urandom_range(1, 31);
            6:       p = 33'($urandom_range(2, 65536));
            default: p = {1'b0, $urandom} | 33'd2;
        endcase
        case ($urandom_range(0, 7))
            0:       lq = 7'd0;
            1:       lq = 7'd64;
            2:       lq = 7'($urandom_range(65, 127));
            3:       lq = 7'd63;
            default: lq = 7'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 5))
            0:       rb = 6'd0;
            1:       rb = 6'd63;
            2:       rb = 6'd1;
            default: rb = 6'($urandom_range(1, 63));
        endcase
        case ($urandom_range(0, 6))
            0, 1:    pk = 6'd0;
            2:       pk = 6'd1;
            3:       pk = 6'd32;
            4:       pk = 6'($urandom_range(33, 63));
            default: pk = 6'($urandom_range(2, 32));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit [32:0] p;
        bit [6:0]  lq;
        bit [5:0]  rb;
        bit [5:0]  pk;
        int        n_recs;
        int        len;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        dig_if.valid       = 1'b0;
        dig_if.digit       = '0;
        dig_if.entry_index = '0;
        dig_if.last        = 1'b0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        cycle_count        = 0;
        n_settings         = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers, single and multi-digit records
        send_digit(64'd0, 32'd0, 1'b1);
        send_digit(ONES, 32'hFFFF_FFFF, 1'b1);
        send_digit(64'd5, 32'd0, 1'b0);
        send_digit(64'd7, 32'd0, 1'b0);
        send_digit(64'd9, 32'd3, 1'b1);
        drain_phase();

        // Largest modulus, no log_q masking, widest field, slot past 64 bits
        set_config(P_MAX, 7'd64, 6'd63, 6'd32);
        send_digit(ONES, 32'd0, 1'b0);
        send_digit(ONES, 32'd0, 1'b0);
        send_digit(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_digit(64'd12345, 32'd1, 1'b1);
        drain_phase();

        // Zero modulus: plain pass-through, weight drops to 0 after digit 0
        set_config(33'd0, 7'd127, 6'd1, 6'd0);
        send_digit(ONES, 32'd0, 1'b0);
        send_digit(64'd3, 32'd0, 1'b0);
        send_digit(64'd5, 32'd0, 1'b1);
        drain_phase();

        // Modulus one and q of one; empty mask with packing on
        set_config(33'd1, 7'd0, 6'd0, 6'd1);
        send_digit(ONES, 32'd5, 1'b0);
        send_digit(64'd1, 32'd5, 1'b1);
        drain_phase();

        // Largest packing register value, zero row_bits
        set_config(33'd3, 7'd0, 6'd0, 6'd63);
        send_digit(64'd7, 32'd62, 1'b1);
        drain_phase();

        // Smallest nonzero log_q with a near-max modulus
        set_config(P_MAX - 33'd1, 7'd1, 6'd32, 6'd2);
        send_digit(64'd0, 32'd1, 1'b0);
        send_digit(64'd1, 32'd1, 1'b0);
        send_digit(ONES, 32'd1, 1'b1);
        drain_phase();

        // Shift beyond the word edge and at the last bit of the word
        set_config(33'd65537, 7'd63, 6'd63, 6'd63);
        send_digit({$urandom, $urandom}, 32'd62, 1'b1);
        send_digit(ONES, 32'd1, 1'b1);
        drain_phase();

        // Random part: one register setting per phase, records of random
        // length with random content
        while (sb.n_digits < DIGIT_TARGET) begin
            random_config(p, lq, rb, pk);
            set_config(p, lq, rb, pk);
            n_recs = $urandom_range(4, 24);
            for (int r = 0; r < n_recs; r++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_digit(rand_digit(), rand_index(), k == len - 1);
            end
            drain_phase();
        end

        $display("Covered %0d digits in %0d records, %0d elements checked, %0d settings",
                 sb.n_digits, sb.n_records, sb.n_checked, n_settings);
        $display("Settings spanned zero and unit moduli, q up to and past 2^64, packed fields");
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("PASS base_p_record_reconstruct");
        end else begin
            $display("%0d errors, %0d elements outstanding", sb.n_errors, sb.pending());
            $display("FAIL base_p_record_reconstruct");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bprr_pkg.sv
hdl/bprr_in_if.sv
hdl/bprr_out_if.sv
hdl/bprr_divider.sv
hdl/base_p_record_reconstruct.sv
dv/tb_base_p_record_reconstruct.sv
